FILE: rtl/core/mwcrc_pkg.sv
`timescale 1ns / 1ps

package mwcrc_pkg;

  typedef enum logic [1:0] {
    CRC_W8  = 2'd0,
    CRC_W10 = 2'd1,
    CRC_W16 = 2'd2,
    CRC_W32 = 2'd3
  } crc_sel_t;

  localparam logic [31:0] POLY_W8  = 32'h0000_0007;
  localparam logic [31:0] POLY_W10 = 32'h0000_0233;
  localparam logic [31:0] POLY_W16 = 32'h0000_1021;
  localparam logic [31:0] POLY_W32 = 32'h04C1_1DB7;

  function automatic logic [31:0] sel_mask(crc_sel_t sel);
    logic [31:0] m;
    case (sel)
      CRC_W8:  m = 32'h0000_00FF;
      CRC_W10: m = 32'h0000_03FF;
      CRC_W16: m = 32'h0000_FFFF;
      CRC_W32: m = 32'hFFFF_FFFF;
      default: m = 32'h0000_00FF;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] sel_poly(crc_sel_t sel);
    logic [31:0] p;
    case (sel)
      CRC_W8:  p = POLY_W8;
      CRC_W10: p = POLY_W10;
      CRC_W16: p = POLY_W16;
      CRC_W32: p = POLY_W32;
      default: p = POLY_W8;
    endcase
    return p;
  endfunction

  function automatic logic [31:0] sel_top(crc_sel_t sel);
    logic [31:0] t;
    case (sel)
      CRC_W8:  t = 32'h0000_0080;
      CRC_W10: t = 32'h0000_0200;
      CRC_W16: t = 32'h0000_8000;
      CRC_W32: t = 32'h8000_0000;
      default: t = 32'h0000_0080;
    endcase
    return t;
  endfunction

  // left shift that puts the byte at the top of the selected width
  function automatic logic [4:0] sel_byte_shift(crc_sel_t sel);
    logic [4:0] s;
    case (sel)
      CRC_W8:  s = 5'd0;
      CRC_W10: s = 5'd2;
      CRC_W16: s = 5'd8;
      CRC_W32: s = 5'd24;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/mwcrc_byte_step.sv
`timescale 1ns / 1ps

module mwcrc_byte_step (
  input  mwcrc_pkg::crc_sel_t sel,
  input  logic [31:0]         crc_in,
  input  logic [7:0]          data_byte,
  output logic [31:0]         crc_out
);

  logic [31:0] mask;
  logic [31:0] poly;
  logic [31:0] top;

  assign mask = mwcrc_pkg::sel_mask(sel);
  assign poly = mwcrc_pkg::sel_poly(sel);
  assign top  = mwcrc_pkg::sel_top(sel);

  // eight MSB-first polynomial steps, unrolled
  always_comb begin
    logic [31:0] c;
    c = crc_in & mask;
    c = c ^ ({24'd0, data_byte} << mwcrc_pkg::sel_byte_shift(sel));
    for (int i = 0; i < 8; i++) begin
      if ((c & top) != 32'd0) begin
        c = ((c << 1) ^ poly) & mask;
      end else begin
        c = (c << 1) & mask;
      end
    end
    crc_out = c;
  end

endmodule

FILE: rtl/core/multi_width_crc_byte_engine.sv
`timescale 1ns / 1ps

// MSB-first, non-reflected CRC over a byte stream, width selected by
// cfg_wr_data: 0 = CRC-8 (0x07), 1 = CRC-10 (0x233), 2 = CRC-16 (0x1021),
// 3 = CRC-32 (0x04C11DB7); zero init, no final XOR. Each input transaction
// returns one output transaction with the running CRC, zero above the
// selected width; in_start_of_message restarts from zero. Each byte passes
// through the input register, then the unrolled byte step into the CRC/result
// register, and one byte is taken per cycle while out_stall is low.
// Change the width only while no transaction is in flight.
module multi_width_crc_byte_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_crc_value
);

  mwcrc_pkg::crc_sel_t width_sel_r;
  logic                a_vld_r, a_vld_nxt;
  logic [7:0]          a_byte_r;
  logic                a_start_r;
  logic                out_vld_r, out_vld_nxt;
  logic [31:0]         crc_r, crc_nxt;
  logic [31:0]         step_out;
  logic                a_adv;
  logic                in_acc;

  assign a_adv    = a_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = a_vld_r && !a_adv;
  assign in_acc   = in_valid && !in_stall;

  mwcrc_byte_step u_step (
    .sel       (width_sel_r),
    .crc_in    (a_start_r ? 32'd0 : crc_r),
    .data_byte (a_byte_r),
    .crc_out   (step_out)
  );

  always_comb begin
    a_vld_nxt = a_vld_r;
    if (in_acc) begin
      a_vld_nxt = 1'b1;
    end else if (a_adv) begin
      a_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (a_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
    crc_nxt = a_adv ? step_out : crc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_sel_r <= mwcrc_pkg::CRC_W8;
      a_vld_r     <= 1'b0;
      out_vld_r   <= 1'b0;
      crc_r       <= 32'd0;
    end else begin
      if (cfg_wr_en) begin
        width_sel_r <= mwcrc_pkg::crc_sel_t'(cfg_wr_data);
      end
      a_vld_r   <= a_vld_nxt;
      out_vld_r <= out_vld_nxt;
      crc_r     <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_byte_r  <= in_data_byte;
      a_start_r <= in_start_of_message;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_crc_value = crc_r;

`ifndef SYNTH
  a_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((crc_r & ~mwcrc_pkg::sel_mask(width_sel_r)) == 32'd0))
    else $error("crc has bits above selected width");

  a_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !a_vld_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    a_adv |=> (out_vld_r && crc_r == $past(step_out)))
    else $error("advanced transaction did not reach result register");

  a_crc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!a_adv && !$past(!rst_n)) |=> $stable(crc_r))
    else $error("crc changed without a transaction");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_start_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_crc_value;

  multi_width_crc_byte_engine dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_start_of_message (in_start_of_message),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_crc_value       (out_crc_value)
  );

  mwcrc_pkg::crc_sel_t width_sel;
  logic [31:0] crc_state;
  logic [31:0] crc_expected_q[$];
  bit          idle_on;
  int          errors;
  int          bytes_sent;
  int          crcs_checked;
  int          width_writes;
  int          input_stall_cycles;
  int          hold_reqs;
  int          hold_served;
  int          hold_cnt;
  int          stall_left;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] crc_after_byte(logic [31:0] prev,
                                                 mwcrc_pkg::crc_sel_t sel,
                                                 logic [7:0] b);
    int unsigned w;
    logic [31:0] poly;
    logic [31:0] mask;
    logic [31:0] c;
    case (sel)
      mwcrc_pkg::CRC_W8: begin
        w = 8;
        poly = mwcrc_pkg::POLY_W8;
      end
      mwcrc_pkg::CRC_W10: begin
        w = 10;
        poly = mwcrc_pkg::POLY_W10;
      end
      mwcrc_pkg::CRC_W16: begin
        w = 16;
        poly = mwcrc_pkg::POLY_W16;
      end
      default: begin
        w = 32;
        poly = mwcrc_pkg::POLY_W32;
      end
    endcase
    mask = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    c = (prev & mask) ^ ({24'd0, b} << (w - 8));
    for (int i = 0; i < 8; i++) begin
      if (c[w-1]) c = ((c << 1) ^ poly) & mask;
      else c = (c << 1) & mask;
    end
    return c;
  endfunction

  // receiver: random stall bursts, plus long holds on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
      hold_served <= 0;
      stall_left <= 0;
    end else if (hold_reqs != hold_served) begin
      hold_served <= hold_served + 1;
      hold_cnt <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) input_stall_cycles++;
      if (out_valid && !out_stall) begin
        if (crc_expected_q.size() == 0) begin
          $display("%0t: unexpected CRC transaction, expected none, actual %08h",
                   $time, out_crc_value);
          errors++;
        end else begin
          if (out_crc_value !== crc_expected_q[0]) begin
            $display("%0t: crc_value mismatch, expected %08h, actual %08h",
                     $time, crc_expected_q[0], out_crc_value);
            errors++;
          end
          void'(crc_expected_q.pop_front());
          crcs_checked++;
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic som);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_start_of_message <= som;
    do @(posedge clk); while (in_stall);
    if (som) crc_state = 32'd0;
    crc_state = crc_after_byte(crc_state, width_sel, b);
    crc_expected_q.push_back(crc_state);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (crc_expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_width(mwcrc_pkg::crc_sel_t sel);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= sel;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_sel = sel;
    width_writes++;
  endtask

  task automatic send_messages(int n_items);
    int count;
    int len;
    logic som;
    count = 0;
    while (count < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      for (int j = 0; j < len; j++) begin
        if (j == 0) som = ($urandom_range(0, 9) != 0);
        else som = ($urandom_range(0, 49) == 0);
        send_byte(8'($urandom_range(0, 255)), som);
      end
      count += len;
    end
  endtask

  // default width after reset, then each width, with extreme bytes
  task automatic test_directed();
    mwcrc_pkg::crc_sel_t sel;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    for (int k = 1; k < 4; k++) begin
      sel = mwcrc_pkg::crc_sel_t'(k);
      set_width(sel);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'hA5, 1'b0);
    end
    // width changed mid-message: stored CRC narrowed, then widened
    set_width(mwcrc_pkg::CRC_W8);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    set_width(mwcrc_pkg::CRC_W32);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h7E, 1'b0);
  endtask

  task automatic test_backpressure();
    wait_drain();
    hold_reqs <= hold_reqs + 1;
    send_messages(64);
  endtask

  task automatic test_random_widths();
    for (int p = 0; p < 12; p++) begin
      set_width(mwcrc_pkg::crc_sel_t'(2'($urandom_range(0, 3))));
      send_messages(105);
    end
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    set_width(mwcrc_pkg::CRC_W32);
    send_messages(100);
    set_width(mwcrc_pkg::CRC_W10);
    send_messages(100);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = mwcrc_pkg::CRC_W8;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_start_of_message = 1'b0;
    width_sel = mwcrc_pkg::CRC_W8;
    crc_state = 32'd0;
    idle_on = 1'b1;
    errors = 0;
    bytes_sent = 0;
    crcs_checked = 0;
    width_writes = 0;
    input_stall_cycles = 0;
    hold_reqs = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_widths();
    test_streaming();

    wait_drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d byte transactions over %0d width writes (all four widths),",
             bytes_sent, width_writes);
    $display("%0d CRC results checked, %0d cycles of input backpressure, %0d errors.",
             crcs_checked, input_stall_cycles, errors);
    if (errors == 0) begin
      $display("** multi_width_crc_byte_engine: PASSED **");
    end else begin
      $display("** multi_width_crc_byte_engine: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d CRC results still outstanding", $time,
             crc_expected_q.size());
    $display("** multi_width_crc_byte_engine: FAILED **");
    $finish;
  end

endmodule
